### rtl/box_overlap_match_counter_assert.svh
// Assertion macros shared by the box overlap match counter RTL.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef BOX_OVERLAP_MATCH_COUNTER_ASSERT_SVH
`define BOX_OVERLAP_MATCH_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define BOMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BOMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bomc_pkg.sv
// Package for the box overlap match counter: sizes, codes, transaction types.
// No dependencies.
`timescale 1ns / 1ps

package bomc_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
    localparam int COORD_W        = 12;
    localparam int AREA_W         = 2 * COORD_W;
    localparam int MIDX_W         = 6;
    localparam int IDX_EXT_W      = (IDX_W > MIDX_W) ? IDX_W : MIDX_W;
    localparam int HIT_W          = 16;
    localparam int Q_DEPTH        = 2;
    localparam int QA_W           = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W           = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_w;
        logic [COORD_W-1:0] box_h;
    } req_t;

    typedef struct packed {
        logic              matched;
        logic [MIDX_W-1:0] match_index;
        logic [HIT_W-1:0]  true_positive_count;
    } res_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } box_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_QUERY
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        box_t     box;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } eng_state_t;

    // Overlap length of [a0, a0+alen) and [b0, b0+blen); never exceeds alen.
    function automatic logic [COORD_W-1:0] overlap_len(
        input logic [COORD_W-1:0] a0,
        input logic [COORD_W-1:0] alen,
        input logic [COORD_W-1:0] b0,
        input logic [COORD_W-1:0] blen
    );
        logic [COORD_W:0] lo;
        logic [COORD_W:0] hi;
        logic [COORD_W:0] a1;
        logic [COORD_W:0] b1;
        logic [COORD_W:0] diff;
        a1   = {1'b0, a0} + {1'b0, alen};
        b1   = {1'b0, b0} + {1'b0, blen};
        lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi   = (a1 < b1) ? a1 : b1;
        diff = hi - lo;
        return (hi > lo) ? diff[COORD_W-1:0] : '0;
    endfunction

endpackage

### rtl/bomc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bomc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bomc_front.sv
// Front end: accepts request transactions, classifies them, drops unknown codes.
// Depends on bomc_pkg.
`timescale 1ns / 1ps

module bomc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  bomc_pkg::req_t   req_data,
    input  bomc_pkg::q_stat_t q_stat,
    output logic             push,
    output bomc_pkg::op_t    push_op
);

    logic          op_vld_reg;
    logic          op_vld_next;
    bomc_pkg::op_t op_reg;
    bomc_pkg::op_t op_next;
    logic          accept;
    logic          known;
    bomc_pkg::op_t decoded;

    assign req_stall = op_vld_reg && q_stat.full;
    assign accept    = req_valid && !req_stall;
    assign push      = op_vld_reg && !q_stat.full;
    assign push_op   = op_reg;

    always_comb
    begin
        known       = 1'b1;
        decoded.box = '{x: req_data.box_x, y: req_data.box_y,
                        w: req_data.box_w, h: req_data.box_h};
        unique case (req_data.req_type)
            bomc_pkg::REQ_CLEAR: decoded.kind = bomc_pkg::OP_CLEAR;
            bomc_pkg::REQ_LOAD:  decoded.kind = bomc_pkg::OP_LOAD;
            bomc_pkg::REQ_QUERY: decoded.kind = bomc_pkg::OP_QUERY;
            default:
            begin
                decoded.kind = bomc_pkg::OP_CLEAR;
                known        = 1'b0;
            end
        endcase

        op_vld_next = op_vld_reg && !push;
        op_next     = op_reg;
        if (accept && known)
        begin
            op_vld_next = 1'b1;
            op_next     = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg <= 1'b0;
        end
        else
        begin
            op_vld_reg <= op_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

endmodule

### rtl/bomc_queue.sv
// Short FIFO of classified operations between the front end and the engine.
// Depends on bomc_pkg.
`timescale 1ns / 1ps

module bomc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bomc_pkg::op_t     push_op,
    input  logic              pop,
    output bomc_pkg::op_t     head,
    output bomc_pkg::q_stat_t q_stat
);

    bomc_pkg::op_t                entry_reg [bomc_pkg::Q_DEPTH];
    logic [bomc_pkg::QA_W-1:0]    wr_ptr_reg;
    logic [bomc_pkg::QA_W-1:0]    wr_ptr_next;
    logic [bomc_pkg::QA_W-1:0]    rd_ptr_reg;
    logic [bomc_pkg::QA_W-1:0]    rd_ptr_next;
    logic [bomc_pkg::QC_W-1:0]    fill_reg;
    logic [bomc_pkg::QC_W-1:0]    fill_next;

    localparam logic [bomc_pkg::QA_W-1:0] PTR_LAST = bomc_pkg::QA_W'(bomc_pkg::Q_DEPTH - 1);

    assign head          = entry_reg[rd_ptr_reg];
    assign q_stat.empty  = (fill_reg == '0);
    assign q_stat.full   = (fill_reg == bomc_pkg::QC_W'(bomc_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### rtl/bomc_back.sv
// Engine: candidate store, count, and the pipelined first-match scan.
// Depends on bomc_pkg and bomc_ram.
`timescale 1ns / 1ps

module bomc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bomc_pkg::q_stat_t q_stat,
    input  bomc_pkg::op_t     head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output bomc_pkg::res_t    res_data
);

    bomc_pkg::eng_state_t state_reg;
    bomc_pkg::eng_state_t state_next;

    logic [bomc_pkg::CNT_W-1:0]  cnt_reg;
    logic [bomc_pkg::CNT_W-1:0]  cnt_next;
    logic [bomc_pkg::HIT_W-1:0]  hit_reg;
    logic [bomc_pkg::HIT_W-1:0]  hit_next;
    logic [bomc_pkg::CNT_W-1:0]  issue_reg;
    logic [bomc_pkg::CNT_W-1:0]  issue_next;
    logic                        found_reg;
    logic                        found_next;
    logic [bomc_pkg::IDX_W-1:0]  fidx_reg;
    logic [bomc_pkg::IDX_W-1:0]  fidx_next;
    logic                        res_vld_reg;
    logic                        res_vld_next;
    bomc_pkg::res_t              res_reg;
    bomc_pkg::res_t              res_next;

    bomc_pkg::box_t              g_reg;
    bomc_pkg::box_t              g_next;
    logic [bomc_pkg::AREA_W-1:0] g_area_reg;
    logic [bomc_pkg::AREA_W-1:0] g_area_next;

    logic                        p1_vld_reg;
    logic [bomc_pkg::IDX_W-1:0]  p1_idx_reg;
    logic                        p2_vld_reg;
    logic [bomc_pkg::IDX_W-1:0]  p2_idx_reg;
    logic [bomc_pkg::COORD_W-1:0] ow_reg;
    logic [bomc_pkg::COORD_W-1:0] oh_reg;
    logic [bomc_pkg::AREA_W-1:0] c_area_reg;
    logic                        p3_vld_reg;
    logic [bomc_pkg::IDX_W-1:0]  p3_idx_reg;
    logic [bomc_pkg::AREA_W-1:0] inter_reg;
    logic                        c_ok_reg;

    logic                        we;
    logic [bomc_pkg::IDX_W-1:0]  waddr;
    logic [bomc_pkg::IDX_W-1:0]  raddr;
    bomc_pkg::box_t              rd_box;
    logic                        issue_en;
    logic                        pipe_clr;
    logic                        pipe_busy;
    logic                        p3_hit;
    logic                        out_free;
    logic [bomc_pkg::HIT_W-1:0]  hit_inc;
    logic [bomc_pkg::IDX_EXT_W-1:0] fidx_ext;
    logic [bomc_pkg::AREA_W+2:0] inter5;
    logic [bomc_pkg::AREA_W+2:0] g_area4;

    bomc_ram #(
        .WIDTH ($bits(bomc_pkg::box_t)),
        .DEPTH (bomc_pkg::MAX_CANDIDATES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (head.box),
        .raddr (raddr),
        .rdata (rd_box)
    );

    assign raddr     = issue_reg[bomc_pkg::IDX_W-1:0];
    assign waddr     = cnt_reg[bomc_pkg::IDX_W-1:0];
    assign issue_en  = (state_reg == bomc_pkg::ST_SCAN) && (issue_reg < cnt_reg);
    assign pipe_clr  = (state_reg == bomc_pkg::ST_SETUP);
    assign pipe_busy = p1_vld_reg || p2_vld_reg || p3_vld_reg;
    assign inter5    = {1'b0, inter_reg, 2'b00} + {3'b000, inter_reg};
    assign g_area4   = {1'b0, g_area_reg, 2'b00};
    assign p3_hit    = p3_vld_reg && c_ok_reg && (inter5 > g_area4);
    assign out_free  = !res_vld_reg || !res_stall;
    assign hit_inc   = (found_reg && (hit_reg != bomc_pkg::HIT_MAX)) ? hit_reg + 1'b1 : hit_reg;
    assign fidx_ext  = bomc_pkg::IDX_EXT_W'(fidx_reg);

    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        issue_next   = issue_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        g_next       = g_reg;
        g_area_next  = g_area_reg;
        res_vld_next = res_vld_reg && res_stall;
        res_next     = res_reg;
        pop          = 1'b0;
        we           = 1'b0;

        unique case (state_reg)
            bomc_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        bomc_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                            hit_next = '0;
                        end
                        bomc_pkg::OP_LOAD:
                        begin
                            if (cnt_reg < bomc_pkg::CNT_W'(bomc_pkg::MAX_CANDIDATES))
                            begin
                                we       = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        bomc_pkg::OP_QUERY:
                        begin
                            g_next     = head.box;
                            state_next = bomc_pkg::ST_SETUP;
                        end
                        default:
                        begin
                            state_next = bomc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bomc_pkg::ST_SETUP:
            begin
                g_area_next = g_reg.w * g_reg.h;
                issue_next  = '0;
                found_next  = 1'b0;
                fidx_next   = '0;
                state_next  = bomc_pkg::ST_SCAN;
            end
            bomc_pkg::ST_SCAN:
            begin
                if (issue_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (p3_hit)
                begin
                    found_next = 1'b1;
                    fidx_next  = p3_idx_reg;
                    state_next = bomc_pkg::ST_DONE;
                end
                else if (!issue_en && !pipe_busy)
                begin
                    state_next = bomc_pkg::ST_DONE;
                end
            end
            bomc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    hit_next                     = hit_inc;
                    res_vld_next                 = 1'b1;
                    res_next.matched             = found_reg;
                    res_next.match_index         = found_reg ?
                                                   fidx_ext[bomc_pkg::MIDX_W-1:0] : '0;
                    res_next.true_positive_count = hit_inc;
                    state_next                   = bomc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bomc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bomc_pkg::ST_IDLE;
            cnt_reg     <= '0;
            hit_reg     <= '0;
            res_vld_reg <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hit_reg     <= hit_next;
            res_vld_reg <= res_vld_next;
            p1_vld_reg  <= !pipe_clr && issue_en;
            p2_vld_reg  <= !pipe_clr && p1_vld_reg;
            p3_vld_reg  <= !pipe_clr && p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg  <= issue_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        g_reg      <= g_next;
        g_area_reg <= g_area_next;
        res_reg    <= res_next;

        p1_idx_reg <= raddr;

        p2_idx_reg <= p1_idx_reg;
        ow_reg     <= bomc_pkg::overlap_len(g_reg.x, g_reg.w, rd_box.x, rd_box.w);
        oh_reg     <= bomc_pkg::overlap_len(g_reg.y, g_reg.h, rd_box.y, rd_box.h);
        c_area_reg <= rd_box.w * rd_box.h;

        p3_idx_reg <= p2_idx_reg;
        inter_reg  <= ow_reg * oh_reg;
        c_ok_reg   <= ({1'b0, c_area_reg} < {g_area_reg, 1'b0});
    end

endmodule

### rtl/box_overlap_match_counter.sv
// Top level of the box overlap match counter: front end, queue, engine.
// Depends on bomc_pkg, bomc_front, bomc_queue, bomc_back and the assert header.
//
//   channel  | signals                      | payload
//   ---------+------------------------------+-----------------
//   request  | req_valid, req_stall         | req_data (req_t)
//   result   | res_valid, res_stall         | res_data (res_t)
//
// Clear and load are handled in the engine's idle state; unknown request codes are dropped.
// A query steps through pop, setup, one store read per candidate, three compare stages,
// one drain check and the finish step.
// Reset clears counts and control; the candidate store needs no clearing pass.
// A full result register holds the engine at the end of a query only; the
// two-entry queue keeps taking requests until full while the engine scans or stalls.
`timescale 1ns / 1ps
`include "box_overlap_match_counter_assert.svh"

module box_overlap_match_counter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bomc_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_stall,
    output bomc_pkg::res_t res_data
);

    bomc_pkg::q_stat_t q_stat;
    logic              push;
    bomc_pkg::op_t     push_op;
    logic              pop;
    bomc_pkg::op_t     head;
    logic              res_hit;

    bomc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_op   (push_op)
    );

    bomc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    bomc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assign res_hit = res_valid && res_data.matched;

    `BOMC_ASSERT_NOW(a_queue_flags, q_stat.full, !q_stat.empty, "queue full and empty")
    `BOMC_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
    `BOMC_ASSERT_NOW(a_stall_cause, req_stall, q_stat.full, "request stall without full queue")
    `BOMC_ASSERT_NOW(a_match_cnt, res_hit, |res_data.true_positive_count, "match with zero count")

endmodule
